### src/psa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, codes and field widths for the pooled slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int SLOTS_PER_POOL_DEF = 256;
    localparam int POOLS = 4;
    localparam int POOL_W = 2;
    localparam int FUNC_W = 2;
    localparam int TAG_W = 9;
    localparam int STATUS_W = 2;
    localparam int GRANT_W = 8;
    localparam int CNT_OUT_W = 9;
    localparam int REFS_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC       = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE_ALL = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADTAG = 2'd2;

    typedef enum logic [1:0] {
        ADDR_CLR_BASE  = 2'd0,
        ADDR_POOL_BASE = 2'd1,
        ADDR_HW        = 2'd2,
        ADDR_TAG       = 2'd3
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        logic      addr_load;
        addr_sel_t addr_sel;
        logic      addr_inc;
        logic      mem_clear;
        logic      update;
        logic      pools_clear;
        logic      set_full;
        logic      set_badtag;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              handle_valid;
        logic              hw_below_cap;
        logic              tag_bad;
        logic              refs_zero;
        logic              scan_last;
        logic              clear_last;
        logic              out_free;
    } sts_t;

endpackage

### src/psa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer for the slot allocator: decode, memory read, update, clear sweep
// and result hand-off.
// ----------------------------------------------------------------------------
module psa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  psa_pkg::sts_t sts,
    output psa_pkg::cmd_t cmd
);
    import psa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_READ   = 6'b000100,
        S_EVAL   = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   clear_reply_reg, clear_reply_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd              = '0;
        state_next       = state_reg;
        clear_reply_next = clear_reply_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.func)
                    FUNC_ALLOC: begin
                        cmd.addr_load = 1'b1;
                        cmd.addr_sel  = sts.hw_below_cap ? ADDR_HW : ADDR_POOL_BASE;
                        state_next    = S_READ;
                    end
                    FUNC_RELEASE: begin
                        if (!sts.handle_valid) begin
                            state_next = S_DONE;
                        end else if (sts.tag_bad) begin
                            cmd.set_badtag = 1'b1;
                            state_next     = S_DONE;
                        end else begin
                            cmd.addr_load = 1'b1;
                            cmd.addr_sel  = ADDR_TAG;
                            state_next    = S_READ;
                        end
                    end
                    FUNC_RELEASE_ALL: begin
                        cmd.addr_load    = 1'b1;
                        cmd.addr_sel     = ADDR_CLR_BASE;
                        clear_reply_next = 1'b1;
                        state_next       = S_CLEAR;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (sts.func == FUNC_ALLOC && !sts.hw_below_cap) begin
                    if (sts.refs_zero) begin
                        cmd.update = 1'b1;
                        state_next = S_DONE;
                    end else if (sts.scan_last) begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        cmd.addr_inc = 1'b1;
                        state_next   = S_READ;
                    end
                end else begin
                    cmd.update = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_CLEAR: begin
                cmd.mem_clear = 1'b1;
                if (sts.clear_last) begin
                    cmd.pools_clear  = 1'b1;
                    clear_reply_next = 1'b0;
                    state_next       = clear_reply_reg ? S_DONE : S_IDLE;
                end else begin
                    cmd.addr_inc = 1'b1;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clear_reply_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clear_reply_reg <= clear_reply_next;
        end
    end

endmodule

### src/psa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_datapath
// Reference count memory, per-pool live and high-water counters, operand
// capture and the result register.
// ----------------------------------------------------------------------------
module psa_datapath #(
    parameter int SLOTS_PER_POOL = psa_pkg::SLOTS_PER_POOL_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [psa_pkg::FUNC_W-1:0]      s_func,
    input  logic [psa_pkg::POOL_W-1:0]      s_pool,
    input  logic                            s_handle_valid,
    input  logic [psa_pkg::TAG_W-1:0]       s_slot_tag,
    input  psa_pkg::cmd_t                   cmd,
    output psa_pkg::sts_t                   sts,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [psa_pkg::STATUS_W-1:0]    m_status,
    output logic [psa_pkg::GRANT_W-1:0]     m_granted_slot,
    output logic [psa_pkg::CNT_OUT_W-1:0]   m_live_count,
    output logic [psa_pkg::CNT_OUT_W-1:0]   m_high_water
);
    import psa_pkg::*;

    localparam int SW    = $clog2(SLOTS_PER_POOL);
    localparam int AW    = SW + POOL_W;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = $clog2(SLOTS_PER_POOL + 1);
    localparam logic [CW-1:0] CAP      = CW'(SLOTS_PER_POOL);
    localparam logic [SW-1:0] LAST_OFF = SW'(SLOTS_PER_POOL - 1);

    logic [FUNC_W-1:0] func_reg;
    logic [POOL_W-1:0] pool_reg;
    logic              hv_reg;
    logic [TAG_W-1:0]  tag_reg;

    logic [AW-1:0]     addr_reg, addr_next;
    logic [REFS_W-1:0] mem [DEPTH];
    logic [REFS_W-1:0] rdata_reg;
    logic              wr_en;
    logic [REFS_W-1:0] wr_data;

    logic [CW-1:0] hw_reg [POOLS];
    logic [CW-1:0] hw_next [POOLS];
    logic [CW-1:0] live_reg [POOLS];
    logic [CW-1:0] live_next [POOLS];

    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [GRANT_W-1:0]   granted_reg, granted_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [GRANT_W-1:0]   m_granted_reg;
    logic [CNT_OUT_W-1:0] m_live_reg;
    logic [CNT_OUT_W-1:0] m_hw_reg;

    logic [SW-1:0] off;
    logic [CW-1:0] pool_hw;
    logic [CW-1:0] pool_live;
    logic          refs_zero;

    assign off       = addr_reg[SW-1:0];
    assign pool_hw   = hw_reg[pool_reg];
    assign pool_live = live_reg[pool_reg];
    assign refs_zero = (rdata_reg == '0);

    always_comb begin
        sts.func         = func_reg;
        sts.handle_valid = hv_reg;
        sts.hw_below_cap = (pool_hw < CAP);
        sts.tag_bad      = (32'(tag_reg) >= 32'(SLOTS_PER_POOL)) ||
                           (32'(tag_reg) > 32'(pool_hw));
        sts.refs_zero    = refs_zero;
        sts.scan_last    = (off == LAST_OFF);
        sts.clear_last   = &addr_reg;
        sts.out_free     = !m_valid_reg || m_ready;
    end

    // address register
    always_comb begin
        addr_next = addr_reg;
        if (cmd.addr_load) begin
            case (cmd.addr_sel)
                ADDR_CLR_BASE:  addr_next = '0;
                ADDR_POOL_BASE: addr_next = {pool_reg, {SW{1'b0}}};
                ADDR_HW:        addr_next = {pool_reg, pool_hw[SW-1:0]};
                ADDR_TAG:       addr_next = {pool_reg, SW'(tag_reg)};
                default:        addr_next = '0;
            endcase
        end else if (cmd.addr_inc) begin
            addr_next = AW'(addr_reg + 1'b1);
        end
    end

    // reference count write
    always_comb begin
        wr_en   = 1'b0;
        wr_data = '0;
        if (cmd.mem_clear) begin
            wr_en = 1'b1;
        end else if (cmd.update) begin
            if (func_reg == FUNC_ALLOC) begin
                wr_en   = 1'b1;
                wr_data = (&rdata_reg) ? rdata_reg : REFS_W'(rdata_reg + 1'b1);
            end else if (!refs_zero) begin
                wr_en   = 1'b1;
                wr_data = REFS_W'(rdata_reg - 1'b1);
            end
        end
    end

    // pool counters and status
    always_comb begin
        hw_next      = hw_reg;
        live_next    = live_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        if (cmd.capture) begin
            status_next  = STAT_OK;
            granted_next = '0;
        end
        if (cmd.set_full) begin
            status_next = STAT_FULL;
        end
        if (cmd.set_badtag) begin
            status_next = STAT_BADTAG;
        end
        if (cmd.pools_clear) begin
            for (int i = 0; i < POOLS; i++) begin
                hw_next[i]   = '0;
                live_next[i] = '0;
            end
        end else if (cmd.update) begin
            if (func_reg == FUNC_ALLOC) begin
                granted_next = GRANT_W'(off);
                if (pool_live < CAP) begin
                    live_next[pool_reg] = CW'(pool_live + 1'b1);
                end
                if (pool_hw < CAP) begin
                    hw_next[pool_reg] = CW'(pool_hw + 1'b1);
                end
            end else if (rdata_reg == REFS_W'(1)) begin
                if (pool_live != '0) begin
                    live_next[pool_reg] = CW'(pool_live - 1'b1);
                end
                if (pool_hw != '0 && CW'(CW'(off) + CW'(1)) == pool_hw) begin
                    hw_next[pool_reg] = CW'(pool_hw - 1'b1);
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr_reg] <= wr_data;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            pool_reg <= s_pool;
            hv_reg   <= s_handle_valid;
            tag_reg  <= s_slot_tag;
        end
        status_reg  <= status_next;
        granted_reg <= granted_next;
        if (cmd.out_load) begin
            m_status_reg  <= status_reg;
            m_granted_reg <= granted_reg;
            m_live_reg    <= CNT_OUT_W'(32'(pool_live));
            m_hw_reg      <= CNT_OUT_W'(32'(pool_hw));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < POOLS; i++) begin
                hw_reg[i]   <= '0;
                live_reg[i] <= '0;
            end
        end else begin
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
            hw_reg      <= hw_next;
            live_reg    <= live_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_slot = m_granted_reg;
    assign m_live_count   = m_live_reg;
    assign m_high_water   = m_hw_reg;

endmodule

### src/pooled_slot_allocator_refcount.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooled_slot_allocator_refcount
// Four-pool slot allocator with per-slot reference counts.
// ----------------------------------------------------------------------------
// One item is handled at a time; s_ready is high only while the sequencer is
// idle, and a finished result waits in the output register while the next
// item is taken. Null-handle releases, bad tags and unused codes go from
// decode straight to the result; an allocate from the high-water mark and a
// release go through one read-modify-write of the single-port reference
// count memory. An allocate on a pool whose high-water mark has reached
// capacity scans upward from the pool base for the lowest free slot, one
// slot examined at a time, up to every slot of the pool. Release-all and
// the pass after reset sweep the whole memory one entry per cycle, during
// which no item is accepted.
// ----------------------------------------------------------------------------
module pooled_slot_allocator_refcount #(
    parameter int SLOTS_PER_POOL = psa_pkg::SLOTS_PER_POOL_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [psa_pkg::FUNC_W-1:0]      s_func,
    input  logic [psa_pkg::POOL_W-1:0]      s_pool,
    input  logic                            s_handle_valid,
    input  logic [psa_pkg::TAG_W-1:0]       s_slot_tag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [psa_pkg::STATUS_W-1:0]    m_status,
    output logic [psa_pkg::GRANT_W-1:0]     m_granted_slot,
    output logic [psa_pkg::CNT_OUT_W-1:0]   m_live_count,
    output logic [psa_pkg::CNT_OUT_W-1:0]   m_high_water
);
    import psa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    psa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    psa_datapath #(
        .SLOTS_PER_POOL (SLOTS_PER_POOL)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_func         (s_func),
        .s_pool         (s_pool),
        .s_handle_valid (s_handle_valid),
        .s_slot_tag     (s_slot_tag),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .m_live_count   (m_live_count),
        .m_high_water   (m_high_water)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_grant_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_OK)) |-> (m_granted_slot == '0))
        else $error("slot granted on a failed operation");

    a_live_within_hw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((SLOTS_PER_POOL > 511) || (m_live_count <= m_high_water)))
        else $error("live count above high-water mark");

    a_full_means_all_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_FULL)) |->
        ((SLOTS_PER_POOL > 511) || (32'(m_live_count) == 32'(SLOTS_PER_POOL))))
        else $error("pool reported full with free slots");
`endif

endmodule
